>>> sv/tcr_pkg.sv
// Package holding the shared constants and functions of the text console renderer.
package tcr_pkg;
	localparam int Columns = 80;
	localparam int Rows = 25;
	localparam int TabStop = 8;
	localparam int Cells = Columns * Rows;
	localparam int AddrW = $clog2(Cells);

	localparam logic [2:0] REQ_PRINT = 3'd0;
	localparam logic [2:0] REQ_READ = 3'd1;
	localparam logic [2:0] REQ_SET_CUR = 3'd2;
	localparam logic [2:0] REQ_SET_MOUSE = 3'd3;
	localparam logic [2:0] REQ_MOVE_MOUSE = 3'd4;
	localparam logic [2:0] REQ_MOUSE_SHOW = 3'd5;
	localparam logic [2:0] REQ_CLEAR = 3'd6;
	localparam logic [2:0] REQ_NONE = 3'd7;

	localparam logic [0:0] CFG_ATTR = 1'b0;
	localparam logic [0:0] CFG_CUR_EN = 1'b1;

	localparam logic [7:0] CH_BS = 8'd8;
	localparam logic [7:0] CH_TAB = 8'd9;
	localparam logic [7:0] CH_NL = 8'd10;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Clamp a signed value (up to 10 bits) into 0 .. n-1.
	function automatic logic [6:0] clamp_to(input logic signed [9:0] v, input int n);
		logic [6:0] r;
		if (v < 0)
			r = 7'd0;
		else if (v >= 10'(n))
			r = 7'(n - 1);
		else
			r = v[6:0];
		return r;
	endfunction

	// Attribute shown on the mouse cell: nibbles swapped, masked, forced visible.
	function automatic logic [7:0] mouse_attr(input logic [7:0] a);
		logic [7:0] s;
		s = {a[3:0], a[7:4]} & 8'h7F;
		if (s[7:4] == s[3:0])
			s = s ^ 8'h70;
		return s;
	endfunction
endpackage

>>> sv/text_console_renderer.sv
// Text console renderer: screen store, cursor, mouse cell and request sequencer.
//
// An ordinary request passes through transfer, then result; a read cell
// request passes through transfer, store read, result. A print of a visible
// character writes one store cell. A print that runs off the last
// row scrolls the screen, a copy of (Rows-1)*Columns cells, each a read
// then a write of the store, plus a blank fill of the last Columns cells;
// a clear request writes all Cells cells, one a cycle. After reset a
// clearing pass writes all Cells cells before the first request is taken.
// Results wait in an output register, and the block holds tready low while
// a request is in work.
module text_console_renderer
	import tcr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// req_type[2:0], char_code[10:3], pos_x[18:11], pos_y[26:19], mouse_show[27]
	input  logic [31:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// cell_value[15:0], cursor_col[22:16], cursor_row[27:23], cursor_write[28],
	// cursor_offset[39:29], mouse_visible[40], mouse_was_visible[41],
	// mouse_col[48:42], mouse_row[53:49], scrolled[54]
	output logic [55:0] m_tdata
);
	localparam logic [2:0] ST_INIT = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_READ = 3'd2;
	localparam logic [2:0] ST_FILL = 3'd3;
	localparam logic [2:0] ST_CP_RD = 3'd4;
	localparam logic [2:0] ST_CP_WR = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	localparam logic [AddrW-1:0] LastCell = AddrW'(Cells - 1);
	localparam logic [AddrW-1:0] CopyEnd = AddrW'(Cells - Columns);

	logic [15:0] mem [Cells];
	logic [15:0] rd_q;
	logic        we;
	logic [AddrW-1:0] waddr, raddr;
	logic [15:0] wdata;

	logic [2:0] state_q;
	logic [AddrW-1:0] ptr_q;
	logic [15:0] fill_q;
	logic [7:0] attr_q;
	logic cur_en_q;
	logic [6:0] cur_col_q, mcol_q;
	logic [4:0] cur_row_q, mrow_q;
	logic mshow_q;
	logic [2:0] req_q;
	logic [AddrW-1:0] rdaddr_q;
	logic is_mouse_q;
	logic cwrite_q, wasvis_q, scr_q;

	logic [2:0] req;
	logic [7:0] ch;
	logic signed [7:0] px, py;
	logic [6:0] cx;
	logic [4:0] cy;
	logic [6:0] adv_col;
	logic [7:0] new_col;
	logic adv, bs;
	logic [AddrW-1:0] cur_addr, xy_addr;
	logic [15:0] shown;

	assign req = s_tdata[2:0];
	assign ch = s_tdata[10:3];
	assign px = s_tdata[18:11];
	assign py = s_tdata[26:19];
	assign cx = clamp_to(10'(px), Columns);
	assign cy = 5'(clamp_to(10'(py), Rows));
	assign cur_addr = AddrW'(cur_row_q * Columns) + AddrW'(cur_col_q);
	assign xy_addr = AddrW'(cy * Columns) + AddrW'(cx);

	// Cursor advance distance for the printed byte.
	always_comb begin
		bs = 1'b0;
		adv = 1'b1;
		adv_col = 7'd1;
		unique case (ch)
			CH_NL: adv_col = 7'(Columns) - cur_col_q;
			CH_TAB: adv_col = 7'(TabStop) - 7'(cur_col_q % TabStop);
			CH_BS: begin
				bs = 1'b1;
				adv = 1'b0;
			end
			default: adv_col = 7'd1;
		endcase
		new_col = 8'(cur_col_q) + 8'(adv_col);
	end

	// Store port: one write and one registered read a cycle.
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	// Store access selection for each sequencer state.
	always_comb begin
		we = 1'b0;
		waddr = ptr_q;
		wdata = fill_q;
		raddr = rdaddr_q;
		unique case (state_q)
			ST_INIT, ST_FILL: we = 1'b1;
			ST_CP_RD: raddr = ptr_q + AddrW'(Columns);
			ST_CP_WR: begin
				we = 1'b1;
				wdata = rd_q;
			end
			ST_IDLE: begin
				raddr = xy_addr;
				waddr = cur_addr;
				wdata = {attr_q, ch};
				we = s_tvalid && req == REQ_PRINT && ch != CH_NL && ch != CH_TAB
					&& ch != CH_BS;
			end
			default: ;
		endcase
	end

	assign s_tready = state_q == ST_IDLE;
	assign cfg_ready = 1'b1;
	assign shown = is_mouse_q ? {mouse_attr(rd_q[15:8]), rd_q[7:0]} : rd_q;

	// Request sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			ptr_q <= '0;
			fill_q <= '0;
			attr_q <= 8'd7;
			cur_en_q <= 1'b1;
			cur_col_q <= '0;
			cur_row_q <= '0;
			mcol_q <= 7'(Columns / 2);
			mrow_q <= 5'(Rows / 2);
			mshow_q <= 1'b1;
			m_tvalid <= 1'b0;
			req_q <= '0;
			rdaddr_q <= '0;
			is_mouse_q <= 1'b0;
			cwrite_q <= 1'b0;
			wasvis_q <= 1'b0;
			scr_q <= 1'b0;
			m_tdata <= '0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == CFG_ATTR)
					attr_q <= cfg_data;
				else
					cur_en_q <= cfg_data[0];
			end
			// A result leaving the output register, unless a new one replaces it.
			if (m_tvalid && m_tready && state_q != ST_DONE)
				m_tvalid <= 1'b0;
			unique case (state_q)
				ST_INIT: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == LastCell)
						state_q <= ST_IDLE;
				end
				ST_IDLE: if (s_tvalid) begin
					req_q <= req;
					rdaddr_q <= xy_addr;
					is_mouse_q <= mshow_q && cx == mcol_q && cy == mrow_q;
					cwrite_q <= 1'b0;
					wasvis_q <= 1'b0;
					scr_q <= 1'b0;
					fill_q <= {attr_q, CH_SPACE};
					state_q <= ST_DONE;
					unique case (req)
						REQ_PRINT: begin
							cwrite_q <= cur_en_q;
							if (bs) begin
								if (cur_col_q != 0)
									cur_col_q <= cur_col_q - 1'b1;
							end else if (adv && new_col >= 8'(Columns)) begin
								cur_col_q <= '0;
								if (cur_row_q == 5'(Rows - 1)) begin
									scr_q <= 1'b1;
									ptr_q <= '0;
									state_q <= ST_CP_RD;
								end else
									cur_row_q <= cur_row_q + 1'b1;
							end else
								cur_col_q <= new_col[6:0];
						end
						REQ_READ: state_q <= ST_READ;
						REQ_SET_CUR: if (cx != cur_col_q || cy != cur_row_q) begin
							cur_col_q <= cx;
							cur_row_q <= cy;
							cwrite_q <= cur_en_q;
						end
						REQ_SET_MOUSE: begin
							mcol_q <= cx;
							mrow_q <= cy;
						end
						REQ_MOVE_MOUSE: begin
							mcol_q <= clamp_to(10'($signed({3'b0, mcol_q})) + 10'(px),
								Columns);
							mrow_q <= 5'(clamp_to(10'($signed({5'b0, mrow_q})) + 10'(py),
								Rows));
						end
						REQ_MOUSE_SHOW: begin
							wasvis_q <= mshow_q;
							mshow_q <= s_tdata[27];
						end
						REQ_CLEAR: begin
							ptr_q <= '0;
							state_q <= ST_FILL;
						end
						default: ;
					endcase
				end
				ST_READ: state_q <= ST_DONE;
				ST_CP_RD: state_q <= ST_CP_WR;
				ST_CP_WR: begin
					ptr_q <= ptr_q + 1'b1;
					state_q <= (ptr_q == CopyEnd - 1'b1) ? ST_FILL : ST_CP_RD;
				end
				ST_FILL: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == LastCell)
						state_q <= ST_DONE;
				end
				ST_DONE: if (!m_tvalid || m_tready) begin
					m_tvalid <= 1'b1;
					m_tdata <= {1'b0, scr_q, mrow_q, mcol_q, wasvis_q, mshow_q,
						11'(cur_row_q * Columns) + 11'(cur_col_q), cwrite_q, cur_row_q,
						cur_col_q, (req_q == REQ_READ) ? shown : 16'd0};
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// No request is taken while a sweep of the store is running.
	a_no_take_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL || state_q == ST_CP_RD || state_q == ST_CP_WR) |-> !s_tready)
		else $error("request taken during store sweep");
	// Cursor stays on screen.
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_col_q < 7'(Columns) && cur_row_q < 5'(Rows))
		else $error("cursor off screen");
	// Mouse stays on screen.
	a_mouse_range: assert property (@(posedge clk) disable iff (!arst_n)
		mcol_q < 7'(Columns) && mrow_q < 5'(Rows))
		else $error("mouse off screen");
`endif
endmodule
